@@ hdl/bsgt_pkg.sv @@
// Shared types and constants for the BMP stream gray and threshold filter.
`default_nettype none
package bsgt_pkg;

	localparam logic [31:0] POS_OFFSET = 32'd10;
	localparam logic [31:0] POS_WIDTH = 32'd18;
	localparam logic [31:0] POS_HEIGHT = 32'd22;
	localparam logic [31:0] POS_WIDTH_LAST = 32'd21;
	localparam logic [31:0] POS_HEIGHT_LAST = 32'd25;
	localparam logic [31:0] HEADER_END = 32'd26;

	localparam logic [7:0] THRESHOLD = 8'd128;
	localparam logic [7:0] WHITE = 8'hff;
	localparam logic [7:0] BLACK = 8'h00;

	// floor(x / 3) equals (x * 683) >> 11 for every sum of three bytes.
	localparam logic [9:0] DIV3_MUL = 10'd683;
	localparam int DIV3_SHIFT = 11;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE = 2'd1;
	localparam logic [1:0] CNT_TWO = 2'd2;
	localparam logic [1:0] CNT_THREE = 2'd3;

	typedef struct packed {
		logic [1:0] count;
		logic [2:0][7:0] data;
	} bsgt_group_t;

endpackage
`default_nettype wire

@@ hdl/bsgt_parser.sv @@
// Header capture, pixel tracking and filtering of one file byte per step.
`default_nettype none
module bsgt_parser import bsgt_pkg::*; #(
	parameter int MAX_WIDTH = 8192,
	parameter int MAX_HEIGHT = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  din,
	input  wire logic        eof,
	input  wire logic        gray_mode,
	output bsgt_group_t      group
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = WW + 2;

	logic [31:0]   pos_q, pos_d;
	logic [31:0]   pix_start_q, pix_start_d;
	logic [23:0]   size_q, size_d;
	logic [WW-1:0] width_q, width_d;
	logic [HW-1:0] height_q, height_d;
	logic [RW-1:0] rbi_q, rbi_d;
	logic [HW-1:0] row_q, row_d;
	logic [1:0]    phase_q, phase_d;
	logic [7:0]    held0_q, held1_q;
	logic          held0_we, held1_we;

	logic [31:0]   koff, ksize, raw, clamped;
	logic          in_pix;
	logic [RW-1:0] data_bytes;
	logic [RW:0]   row_bytes, rbi_inc;
	logic [9:0]    sum;
	logic [19:0]   prod;
	logic [7:0]    avg, filt;

	always_comb begin
		pos_d = pos_q;
		pix_start_d = pix_start_q;
		size_d = size_q;
		width_d = width_q;
		height_d = height_q;
		rbi_d = rbi_q;
		row_d = row_q;
		phase_d = phase_q;
		held0_we = 1'b0;
		held1_we = 1'b0;
		group.count = CNT_ONE;
		group.data = {3{din}};
		clamped = '0;

		koff = pos_q - POS_OFFSET;
		ksize = pos_q - POS_WIDTH;
		raw = {din, size_q};

		if (pos_q >= POS_OFFSET && pos_q < POS_WIDTH - 32'd4) begin
			if (pos_q == POS_OFFSET) begin
				pix_start_d = {24'd0, din};
			end else begin
				pix_start_d[8*koff[1:0] +: 8] = din;
			end
		end else if (pos_q >= POS_WIDTH && pos_q < HEADER_END) begin
			if (ksize[1:0] == 2'd0) begin
				size_d = {16'd0, din};
			end else if (ksize[1:0] != 2'd3) begin
				size_d[8*ksize[1:0] +: 8] = din;
			end
			if (pos_q == POS_WIDTH_LAST) begin
				clamped = raw[31] ? 32'd0 : (raw > 32'(MAX_WIDTH) ? 32'(MAX_WIDTH) : raw);
				width_d = clamped[WW-1:0];
			end else if (pos_q == POS_HEIGHT_LAST) begin
				clamped = raw[31] ? 32'd0 : (raw > 32'(MAX_HEIGHT) ? 32'(MAX_HEIGHT) : raw);
				height_d = clamped[HW-1:0];
			end
		end

		in_pix = (pos_q >= HEADER_END) && (pos_q >= pix_start_q)
			&& (row_q < height_q) && (width_q != '0);

		data_bytes = RW'({width_q, 1'b0}) + RW'(width_q);
		row_bytes = ((RW+1)'(data_bytes) + (RW+1)'(3)) & ~(RW+1)'(3);
		rbi_inc = (RW+1)'(rbi_q) + (RW+1)'(1);

		sum = 10'(held0_q) + 10'(held1_q) + 10'(din);
		prod = 20'(sum) * 20'(DIV3_MUL);
		avg = prod[DIV3_SHIFT +: 8];
		filt = gray_mode ? avg : ((avg < THRESHOLD) ? BLACK : WHITE);

		if (in_pix) begin
			if (rbi_q < data_bytes) begin
				if (phase_q == 2'd0) begin
					held0_we = 1'b1;
					phase_d = 2'd1;
					group.count = eof ? CNT_ONE : CNT_NONE;
				end else if (phase_q == 2'd1) begin
					held1_we = 1'b1;
					phase_d = 2'd2;
					group.count = eof ? CNT_TWO : CNT_NONE;
					group.data[0] = held0_q;
				end else begin
					phase_d = 2'd0;
					group.count = CNT_THREE;
					group.data = {3{filt}};
				end
			end
			if (rbi_inc >= row_bytes) begin
				rbi_d = '0;
				row_d = row_q + HW'(1);
			end else begin
				rbi_d = rbi_inc[RW-1:0];
			end
		end

		if (eof) begin
			pos_d = '0;
			pix_start_d = '0;
			size_d = '0;
			width_d = '0;
			height_d = '0;
			rbi_d = '0;
			row_d = '0;
			phase_d = '0;
		end else if (pos_q != '1) begin
			pos_d = pos_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pix_start_q <= '0;
			size_q <= '0;
			width_q <= '0;
			height_q <= '0;
			rbi_q <= '0;
			row_q <= '0;
			phase_q <= '0;
		end else if (step) begin
			pos_q <= pos_d;
			pix_start_q <= pix_start_d;
			size_q <= size_d;
			width_q <= width_d;
			height_q <= height_d;
			rbi_q <= rbi_d;
			row_q <= row_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && held0_we) begin
			held0_q <= din;
		end
		if (step && held1_we) begin
			held1_q <= din;
		end
	end

endmodule
`default_nettype wire

@@ hdl/bsgt_out.sv @@
// Result register that sends the beats of one byte's result group in order.
`default_nettype none
module bsgt_out import bsgt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire bsgt_group_t group,
	output logic             free,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       byte_out,
	output logic             run_last
);

	logic [1:0]      cnt_q;
	logic [1:0]      idx_q;
	logic [2:0][7:0] data_q;
	logic            fire;

	assign out_valid = (cnt_q != CNT_NONE);
	assign run_last = (idx_q == cnt_q - 2'd1);
	assign fire = out_valid && !out_stall;
	assign free = !out_valid || (fire && run_last);

	always_comb begin
		case (idx_q)
			2'd0: byte_out = data_q[0];
			2'd1: byte_out = data_q[1];
			2'd2: byte_out = data_q[2];
			default: byte_out = data_q[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_NONE;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= group.count;
			idx_q <= '0;
		end else if (fire) begin
			if (run_last) begin
				cnt_q <= CNT_NONE;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= group.data;
		end
	end

endmodule
`default_nettype wire

@@ hdl/bmp_stream_gray_threshold_filter.sv @@
// Top level of the BMP stream gray and threshold filter.
// A 24-bit BMP file enters one byte per beat and leaves in the same order with every
// pixel replaced by its gray average (gray_mode = 1) or by black or white at 128
// (gray_mode = 0); header, row padding and trailing bytes pass unchanged. An input
// byte is taken every cycle unless in_stall is high, waits in the input register until
// the parser takes it; its results then sit in the result register: zero beats for a
// held blue or green byte, three for a red byte, one otherwise. With out_stall low the
// output port moves one beat per cycle, so the next pixel's blue and green bytes are
// absorbed while a pixel's three beats leave; the sustained rate is one byte per cycle
// in and out. run_last marks each group's final beat. The user must write gray_mode
// through the always-ready cfg channel only while the block is idle; it is not enforced.
`default_nettype none
module bmp_stream_gray_threshold_filter import bsgt_pkg::*; #(
	parameter int MAX_WIDTH = 8192,
	parameter int MAX_HEIGHT = 8192
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] byte_in,
	input  wire logic       end_of_file,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      byte_out,
	output logic            run_last,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       gray_mode
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;
	logic        gray_mode_q;
	logic        step;
	logic        grp_free;
	logic        grp_load;
	bsgt_group_t group;

	assign cfg_ready = 1'b1;
	assign step = valid_s1 && ((group.count == CNT_NONE) || grp_free);
	assign grp_load = step && (group.count != CNT_NONE);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			gray_mode_q <= gray_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
			eof_s1 <= end_of_file;
		end
	end

	bsgt_parser #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.din(byte_s1),
		.eof(eof_s1),
		.gray_mode(gray_mode_q),
		.group(group)
	);

	bsgt_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(grp_load),
		.group(group),
		.free(grp_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_out(byte_out),
		.run_last(run_last)
	);

	// A result group is only loaded into an empty or emptying result register.
	assert property (@(posedge clk) disable iff (!arst_n) grp_load |-> grp_free)
		else $error("result group loaded over undelivered beats");

	// After the final beat leaves with nothing new loaded, the output goes quiet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && run_last && !grp_load) |=> !out_valid)
		else $error("output valid after final beat of group");

	// A byte held in the input register keeps its value until the parser takes it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && $stable(byte_s1) && $stable(eof_s1)))
		else $error("held input byte lost or changed");

endmodule
`default_nettype wire
